FILE: design/wstm_pkg.sv
// ----------------------------------------------------------------------------
// wstm_pkg
// Shared types and constants for the weekly start-time match table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wstm_pkg;

    localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;
    localparam logic [11:0] START_WINDOW    = 12'd2;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_UPDATE   = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_READ     = 3'd4,
        OP_CHECK    = 3'd5,
        OP_VALIDATE = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    // register index on the configuration port
    typedef enum logic {
        REG_VALVE_MIN = 1'b0,
        REG_VALVE_MAX = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  valve;
        logic [6:0]  day_mask;
        logic [10:0] start_minute;
        logic        enabled;
    } entry_t;

    // input item, slot in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [2:0]  now_day;
        logic [10:0] now_minute;
        logic        enabled;
        logic [10:0] start_minute;
        logic [6:0]  day_mask;
        logic [7:0]  valve;
        logic [4:0]  slot;
    } in_item_t;

    // result item, ok in bit 0
    typedef struct packed {
        logic        read_enabled;
        logic [10:0] read_start;
        logic [6:0]  read_days;
        logic [7:0]  read_valve;
        logic [5:0]  count;
        logic [4:0]  match_slot;
        logic        found;
        logic        ok;
    } res_item_t;

    function automatic logic entry_pending(input entry_t e, input logic [10:0] now,
                                           input logic [2:0] day);
        logic [7:0] days_ext;
        logic       day_hit;
        logic       in_window;
        days_ext  = {1'b0, e.day_mask};   // day 7 selects the zero bit
        day_hit   = days_ext[day];
        in_window = (now >= e.start_minute) &&
                    ({1'b0, now} < ({1'b0, e.start_minute} + START_WINDOW));
        return e.enabled && day_hit && in_window;
    endfunction

    function automatic logic entry_invalid(input entry_t e, input logic [7:0] vmin,
                                           input logic [7:0] vmax);
        return (e.valve < vmin) || (e.valve > vmax) ||
               (e.start_minute >= MINUTES_PER_DAY);
    endfunction

endpackage

FILE: design/weekly_start_time_match_table.sv
// ----------------------------------------------------------------------------
// weekly_start_time_match_table
// Schedule entry table with add/update/remove/clear/read/check/validate.
// ----------------------------------------------------------------------------
// One item is taken at a time; the next is accepted as soon as the previous
// result has moved to the output register. Add, update, clear, refused and
// unknown operations go straight to the done state; read fetches one entry.
// Remove, check and validate walk the entry RAM one entry per cycle through
// its single read port: remove shifts the entries above the slot down by one,
// check and validate walk all entries, stopping early at the first match or
// failing entry. The table needs no clearing after reset.
`timescale 1ns / 1ps

module weekly_start_time_match_table #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[4:0], valve[12:5], day_mask[19:13], start_minute[30:20],
    // enabled[31], now_minute[42:32], now_day[45:43], zero[47:46]
    input  logic [47:0] s_tdata,
    // operation[2:0]
    input  logic [2:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], found[1], match_slot[6:2], count[12:7], read_valve[20:13],
    // read_days[27:21], read_start[38:28], read_enabled[39]
    output logic [39:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = CW + 5;

    wstm_pkg::state_t    state_reg, state_next;
    wstm_pkg::op_t       op_reg, op_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       lim_reg, lim_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic                ok_reg, ok_next;
    logic                found_reg, found_next;
    logic [4:0]          match_reg, match_next;
    wstm_pkg::entry_t    rdent_reg, rdent_next;
    logic [10:0]         now_reg, now_next;
    logic [2:0]          day_reg, day_next;
    logic                out_vld_reg, out_vld_next;
    wstm_pkg::res_item_t out_reg, out_next;
    logic [7:0]          vmin_reg, vmax_reg;

    wstm_pkg::in_item_t  in_item;
    wstm_pkg::entry_t    in_entry;
    wstm_pkg::entry_t    rdata;
    logic [26:0]         rdata_raw;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    wstm_pkg::entry_t    mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic                accept;
    logic                slot_ok;
    logic                issue;
    logic                stop;
    logic                cfg_wr;

    assign in_item  = wstm_pkg::in_item_t'(s_tdata);
    assign in_entry = '{valve:        in_item.valve,
                        day_mask:     in_item.day_mask,
                        start_minute: in_item.start_minute,
                        enabled:      in_item.enabled};
    assign rdata    = wstm_pkg::entry_t'(rdata_raw);

    assign s_tready = (state_reg == wstm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign slot_ok  = (CMP_W'(in_item.slot) < CMP_W'(count_reg));
    assign issue    = (idx_reg < lim_reg);

    wstm_ram #(
        .WIDTH (27),
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata_raw)
    );

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        ok_next      = ok_reg;
        found_next   = found_reg;
        match_next   = match_reg;
        rdent_next   = rdent_reg;
        now_next     = now_reg;
        day_next     = day_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_tready;
        mem_we       = 1'b0;
        mem_waddr    = AW'(count_reg);
        mem_wdata    = in_entry;
        mem_raddr    = AW'(idx_reg);
        stop         = 1'b0;

        unique case (state_reg)
            wstm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = wstm_pkg::op_t'(s_tuser);
                    ok_next    = 1'b0;
                    found_next = 1'b0;
                    match_next = '0;
                    rdent_next = '0;
                    now_next   = in_item.now_minute;
                    day_next   = in_item.now_day;
                    state_next = wstm_pkg::ST_DONE;
                    unique case (wstm_pkg::op_t'(s_tuser))
                        wstm_pkg::OP_ADD:
                        begin
                            if (count_reg < CW'(MAX_ENTRIES))
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        wstm_pkg::OP_UPDATE:
                        begin
                            if (slot_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(in_item.slot);
                                ok_next   = 1'b1;
                            end
                        end
                        wstm_pkg::OP_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                ok_next    = 1'b1;
                                idx_next   = CW'(in_item.slot) + 1'b1;
                                lim_next   = count_reg;
                                state_next = wstm_pkg::ST_WALK;
                            end
                        end
                        wstm_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        wstm_pkg::OP_READ:
                        begin
                            if (slot_ok)
                            begin
                                ok_next    = 1'b1;
                                idx_next   = CW'(in_item.slot);
                                lim_next   = CW'(in_item.slot) + 1'b1;
                                state_next = wstm_pkg::ST_WALK;
                            end
                        end
                        wstm_pkg::OP_CHECK, wstm_pkg::OP_VALIDATE:
                        begin
                            ok_next    = 1'b1;
                            idx_next   = '0;
                            lim_next   = count_reg;
                            state_next = wstm_pkg::ST_WALK;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            wstm_pkg::ST_WALK:
            begin
                // data read last cycle arrives now for entry rd_idx_reg
                if (rd_vld_reg)
                begin
                    unique case (op_reg)
                        wstm_pkg::OP_READ:
                        begin
                            rdent_next = rdata;
                            stop       = 1'b1;
                        end
                        wstm_pkg::OP_CHECK:
                        begin
                            if (wstm_pkg::entry_pending(rdata, now_reg, day_reg))
                            begin
                                found_next = 1'b1;
                                match_next = 5'(rd_idx_reg);
                                stop       = 1'b1;
                            end
                        end
                        wstm_pkg::OP_VALIDATE:
                        begin
                            if (wstm_pkg::entry_invalid(rdata, vmin_reg, vmax_reg))
                            begin
                                ok_next = 1'b0;
                                stop    = 1'b1;
                            end
                        end
                        wstm_pkg::OP_REMOVE:
                        begin
                            // shift down by one
                            mem_we    = 1'b1;
                            mem_waddr = AW'(rd_idx_reg - 1'b1);
                            mem_wdata = rdata;
                        end
                        default:
                        begin
                            stop = 1'b1;
                        end
                    endcase
                end

                if (stop || !issue)
                begin
                    if (op_reg == wstm_pkg::OP_REMOVE)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = wstm_pkg::ST_DONE;
                end
                else
                begin
                    mem_raddr   = AW'(idx_reg);
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg;
                    idx_next    = idx_reg + 1'b1;
                end
            end

            wstm_pkg::ST_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_next.ok           = ok_reg;
                    out_next.found        = found_reg;
                    out_next.match_slot   = match_reg;
                    out_next.count        = 6'(count_reg);
                    out_next.read_valve   = rdent_reg.valve;
                    out_next.read_days    = rdent_reg.day_mask;
                    out_next.read_start   = rdent_reg.start_minute;
                    out_next.read_enabled = rdent_reg.enabled;
                    out_vld_next          = 1'b1;
                    state_next            = wstm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = wstm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wstm_pkg::ST_IDLE;
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            idx_reg     <= '0;
            lim_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
            idx_reg     <= idx_next;
            lim_reg     <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        rd_idx_reg <= rd_idx_next;
        ok_reg     <= ok_next;
        found_reg  <= found_next;
        match_reg  <= match_next;
        rdent_reg  <= rdent_next;
        now_reg    <= now_next;
        day_reg    <= day_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmin_reg <= 8'd0;
            vmax_reg <= 8'd255;
        end
        else if (cfg_wr)
        begin
            unique case (wstm_pkg::reg_idx_t'(paddr[2]))
                wstm_pkg::REG_VALVE_MIN: vmin_reg <= pwdata[7:0];
                wstm_pkg::REG_VALVE_MAX: vmax_reg <= pwdata[7:0];
                default:                 vmin_reg <= vmin_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (wstm_pkg::reg_idx_t'(paddr[2]))
            wstm_pkg::REG_VALVE_MIN: prdata = {24'd0, vmin_reg};
            wstm_pkg::REG_VALVE_MAX: prdata = {24'd0, vmax_reg};
            default:                 prdata = '0;
        endcase
    end

    // count never exceeds the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // writes land at or below the current count
    a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CMP_W'(mem_waddr) <= CMP_W'(count_reg)))
        else $error("table write beyond count");

    // returning read data only while walking
    a_rd_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == wstm_pkg::ST_WALK))
        else $error("read data outside walk");

    // a finished item reaches the output register
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wstm_pkg::ST_DONE) && (!out_vld_reg || m_tready) |=> m_tvalid)
        else $error("result not loaded");

endmodule

FILE: design/wstm_ram.sv
// ----------------------------------------------------------------------------
// wstm_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstm_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
